@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stream find-and-replace block
// Register codes, field widths and the control words passed between the
// window cells, the output burst buffer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW             = 8;
  localparam int unsigned LenW              = 4;
  localparam int unsigned WordW             = 64;
  localparam int unsigned CfgIdxW           = 2;
  localparam int unsigned MaxPatternDefault = 8;
  localparam int unsigned ReplMax           = 8;
  localparam int unsigned BurstDepth        = 8;
  localparam int unsigned BurstCntW         = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLen    = 2'd0,
    CfgPatBytes  = 2'd1,
    CfgReplLen   = 2'd2,
    CfgReplBytes = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                                valid;
    logic [BurstCntW-1:0]                n;
    logic                                last;
    logic                                empty;
    logic [BurstDepth-1:0][ByteW-1:0]    bytes;
  } burst_load_t;

endpackage

`default_nettype wire

@@ rtl/sfr_cell.sv @@
// ----------------------------------------------------------------------------
// sfr_cell: one window cell
// Holds one pending byte, takes the incoming byte when it is the write slot,
// compares against its pattern byte and shifts toward the oldest end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell (
  input  logic                         clk_i,
  input  sfr_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         sel_i,
  input  logic [sfr_pkg::ByteW-1:0]    in_byte_i,
  input  logic [sfr_pkg::ByteW-1:0]    right_i,
  input  logic [sfr_pkg::ByteW-1:0]    pat_byte_i,
  output logic [sfr_pkg::ByteW-1:0]    cur_o,
  output logic                         eq_o
);
  import sfr_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;

  assign cur_o = (ctrl_i.load && sel_i) ? in_byte_i : byte_q;
  assign eq_o  = (cur_o == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = ctrl_i.shift ? right_i : cur_o;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

`default_nettype wire

@@ rtl/sfr_burst.sv @@
// ----------------------------------------------------------------------------
// sfr_burst: output burst buffer and output register
// Holds the words produced by one input word and hands them out one per
// cycle, while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_burst (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sfr_pkg::burst_load_t         ld_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sfr_pkg::ByteW-1:0]    out_byte_o,
  output logic                         has_byte_o,
  output logic                         out_last_o
);
  import sfr_pkg::*;

  logic [BurstCntW-1:0]             cnt_q, cnt_d;
  logic [BurstDepth-1:0][ByteW-1:0] data_q, data_d;
  logic                             last_q, last_d;
  logic                             empty_q, empty_d;
  logic                             ovalid_q, ovalid_d;
  logic [ByteW-1:0]                 obyte_q, obyte_d;
  logic                             ohas_q, ohas_d;
  logic                             olast_q, olast_d;
  logic                             out_free;
  logic                             move;

  assign out_free = !ovalid_q || out_ready_i;
  assign move     = (cnt_q != '0) && out_free;
  assign ready_o  = (cnt_q == '0) || ((cnt_q == BurstCntW'(1)) && out_free);

  always_comb begin
    cnt_d   = cnt_q;
    data_d  = data_q;
    last_d  = last_q;
    empty_d = empty_q;
    if (move) begin
      cnt_d = cnt_q - BurstCntW'(1);
      for (int j = 0; j < BurstDepth - 1; j++) begin
        data_d[j] = data_q[j+1];
      end
      data_d[BurstDepth-1] = '0;
    end
    if (ld_i.valid) begin
      cnt_d   = ld_i.n;
      data_d  = ld_i.bytes;
      last_d  = ld_i.last;
      empty_d = ld_i.empty;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    ohas_d   = ohas_q;
    olast_d  = olast_q;
    if (move) begin
      ovalid_d = 1'b1;
      obyte_d  = data_q[0];
      ohas_d   = !empty_q;
      olast_d  = last_q && (cnt_q == BurstCntW'(1));
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    last_q  <= last_d;
    empty_q <= empty_d;
    obyte_q <= obyte_d;
    ohas_q  <= ohas_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign has_byte_o  = ohas_q;
  assign out_last_o  = olast_q;

endmodule

`default_nettype wire

@@ rtl/stream_find_and_replace_top.sv @@
// ----------------------------------------------------------------------------
// stream_find_and_replace_top: streaming find and replace over a byte stream
// Input words carry one text byte and an end mark. Output words carry a byte,
// a byte-present flag and an end mark. Every leftmost, non-overlapping copy
// of the pattern (1 to MaxPattern bytes) is replaced by the replacement text
// (0 to 8 bytes); scanning resumes after the inserted text.
// The cfg channel writes pattern length, pattern bytes, replacement length
// and replacement bytes; cfg_ready_o is always high. Writing the pattern
// length drops any pending bytes. Write registers only while idle.
// An input word's output words pass from the burst buffer, which loads at
// the accepting edge, to the registered output stage when it is free.
// Throughput: one input word per cycle while each word yields at most one
// output word and the output is not stalled; a word that yields more output
// words holds the input while the single output port drains the burst buffer.
// The end mark flushes the window; if that word yields nothing else, one
// empty word with has_byte_o low carries out_last_o.
// Reset clears the window and the burst buffer and restores the register
// defaults. When out_ready_i is low the output word holds and the input
// stalls while any word waits in the burst buffer behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace_top #(
  parameter int unsigned MaxPattern = sfr_pkg::MaxPatternDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sfr_pkg::ByteW-1:0]      in_byte_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sfr_pkg::ByteW-1:0]      out_byte_o,
  output logic                           has_byte_o,
  output logic                           out_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sfr_pkg::WordW-1:0]      cfg_data_i
);
  import sfr_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPattern + 1);

  logic [LenW-1:0]  plen_q, plen_d;
  logic [WordW-1:0] pat_q, pat_d;
  logic [LenW-1:0]  rlen_q, rlen_d;
  logic [WordW-1:0] repl_q, repl_d;
  logic [CntW-1:0]  wc_q, wc_d;

  logic                             accept;
  logic                             cfg_we;
  cfg_reg_e                         cfg_sel;
  logic [CntW-1:0]                  plen_eff;
  logic [LenW-1:0]                  rlen_eff;
  logic [CntW-1:0]                  wc1;
  logic                             full;
  logic                             match;
  logic [MaxPattern-1:0]            eq;
  logic [MaxPattern-1:0]            eq_ok;
  logic [MaxPattern-1:0][ByteW-1:0] cur;
  logic [BurstDepth-1:0][ByteW-1:0] win_bytes;
  logic [BurstDepth-1:0][ByteW-1:0] repl_bytes;
  cell_ctrl_t                       cell_ctrl;
  burst_load_t                      ld;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cfg_sel     = cfg_reg_e'(cfg_index_i);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    if (plen_q == '0) begin
      plen_eff = CntW'(1);
    end else if (plen_q > LenW'(MaxPattern)) begin
      plen_eff = CntW'(MaxPattern);
    end else begin
      plen_eff = plen_q[CntW-1:0];
    end
    rlen_eff = (rlen_q > LenW'(ReplMax)) ? LenW'(ReplMax) : rlen_q;
  end

  assign wc1  = wc_q + CntW'(1);
  assign full = (wc1 >= plen_eff);

  assign cell_ctrl.load  = accept;
  assign cell_ctrl.shift = full && !match;

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    logic [ByteW-1:0] right;
    if (i == MaxPattern - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cur[i+1];
    end
    sfr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .sel_i      (wc_q == CntW'(i)),
      .in_byte_i  (in_byte_i),
      .right_i    (right),
      .pat_byte_i (pat_q[ByteW*i +: ByteW]),
      .cur_o      (cur[i]),
      .eq_o       (eq[i])
    );
    assign eq_ok[i] = eq[i] || (CntW'(i) >= plen_eff);
  end

  assign match = &eq_ok;

  for (genvar j = 0; j < BurstDepth; j++) begin : g_emit
    if (j < MaxPattern) begin : g_win
      assign win_bytes[j] = cur[j];
    end else begin : g_pad
      assign win_bytes[j] = '0;
    end
    assign repl_bytes[j] = repl_q[ByteW*j +: ByteW];
  end

  always_comb begin
    ld.valid = accept;
    ld.last  = in_last_i;
    ld.empty = 1'b0;
    ld.bytes = win_bytes;
    ld.n     = '0;
    if (full && match) begin
      ld.bytes = repl_bytes;
      ld.n     = BurstCntW'(rlen_eff);
    end else if (full && !in_last_i) begin
      ld.n = BurstCntW'(1);
    end else if (in_last_i) begin
      ld.n = BurstCntW'(wc1);
    end
    if (in_last_i && (ld.n == '0)) begin
      ld.bytes = '0;
      ld.empty = 1'b1;
      ld.n     = BurstCntW'(1);
    end
  end

  always_comb begin
    wc_d = wc_q;
    if (accept) begin
      if (in_last_i || (full && match)) begin
        wc_d = '0;
      end else if (full) begin
        wc_d = wc_q;
      end else begin
        wc_d = wc1;
      end
    end
    plen_d = plen_q;
    pat_d  = pat_q;
    rlen_d = rlen_q;
    repl_d = repl_q;
    if (cfg_we) begin
      unique case (cfg_sel)
        CfgPatLen: begin
          plen_d = cfg_data_i[LenW-1:0];
          wc_d   = '0;
        end
        CfgPatBytes:  pat_d  = cfg_data_i;
        CfgReplLen:   rlen_d = cfg_data_i[LenW-1:0];
        CfgReplBytes: repl_d = cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= LenW'(1);
      pat_q  <= '0;
      rlen_q <= '0;
      repl_q <= '0;
      wc_q   <= '0;
    end else begin
      plen_q <= plen_d;
      pat_q  <= pat_d;
      rlen_q <= rlen_d;
      repl_q <= repl_d;
      wc_q   <= wc_d;
    end
  end

  sfr_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o)
  );

`ifndef ASSERT_OFF
  a_wc_below_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q < plen_eff)
    else $error("pending byte count reached pattern length");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> out_last_o)
    else $error("empty word without end mark");

  a_last_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> (wc_q == '0))
    else $error("window not flushed after end mark");
`endif

endmodule

`default_nettype wire

@@ test/stream_find_and_replace_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace_top_test: self-checking bench for the find-and-replace
// Drives byte texts with end marks through the input channel and programs the
// pattern and replacement through the cfg channel between texts. A predictor
// tracks the pending window and queues the output words each input word must
// produce; a checker compares every output word in order. Directed texts hit
// the field extremes, the length clamps, a full-length match with a full
// replacement, the empty end word and writes in the middle of a text; random
// texts follow under changing idle patterns, with one long output stall.
// ----------------------------------------------------------------------------
module stream_find_and_replace_top_test;
  import sfr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleWait  = 4;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has;
    logic             last;
  } out_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [ByteW-1:0]   in_byte;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [ByteW-1:0]   out_byte;
  logic               has_byte;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [WordW-1:0]   cfg_data;

  // predictor state
  logic [LenW-1:0]  pat_len_r;
  logic [WordW-1:0] pat_r;
  logic [LenW-1:0]  rep_len_r;
  logic [WordW-1:0] rep_r;
  logic [ByteW-1:0] win_q [8];
  int unsigned      win_cnt;

  out_word_t expected_words [$];

  int send_gap_pct;
  int recv_stall_pct;
  int ready_hold_cycles;
  int mismatch_count;
  int cycle_count;

  stream_find_and_replace_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .has_byte_o  (has_byte),
    .out_last_o  (out_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int eff_pat_len();
    if (pat_len_r == 0) return 1;
    if (pat_len_r > 8) return 8;
    return int'(pat_len_r);
  endfunction

  function automatic void clear_window();
    int i;
    for (i = 0; i < 8; i++) win_q[i] = '0;
    win_cnt = 0;
  endfunction

  function automatic void drop_oldest();
    int i;
    for (i = 1; i < 8; i++) win_q[i-1] = win_q[i];
    win_q[7] = '0;
    if (win_cnt > 0) win_cnt--;
  endfunction

  // queue the output words that one input word produces
  function automatic void predict_replace(input logic [ByteW-1:0] b, input logic is_last);
    logic [ByteW-1:0] ob [8];
    logic             oh [8];
    out_word_t        w;
    int               plen;
    int               rlen;
    int               n;
    int               i;
    logic             hit;
    plen = eff_pat_len();
    rlen = (rep_len_r > 8) ? 8 : int'(rep_len_r);
    n = 0;
    if (win_cnt > 7) win_cnt = 7;
    win_q[win_cnt] = b;
    win_cnt++;
    if (win_cnt >= plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (win_q[i] != pat_r[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) begin
          ob[n] = rep_r[8*i +: 8];
          oh[n] = 1'b1;
          n++;
        end
        clear_window();
      end else begin
        ob[n] = win_q[0];
        oh[n] = 1'b1;
        n++;
        drop_oldest();
      end
    end
    if (is_last) begin
      while (win_cnt > 0 && n < 8) begin
        ob[n] = win_q[0];
        oh[n] = 1'b1;
        n++;
        drop_oldest();
      end
      clear_window();
      if (n == 0) begin
        ob[0] = '0;
        oh[0] = 1'b0;
        n = 1;
      end
    end
    for (i = 0; i < n; i++) begin
      w.data = ob[i];
      w.has  = oh[i];
      w.last = is_last && (i == n - 1);
      expected_words.push_back(w);
    end
  endfunction

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (ready_hold_cycles > 0) begin
      out_ready = 1'b0;
      ready_hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_words
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.data = out_byte;
      got.has  = has_byte;
      got.last = out_last;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected word: byte %02h has %0b last %0b",
                   got.data, got.has, got.last);
      end else begin
        want = expected_words.pop_front();
        if (want != got) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("mismatch: expected byte %02h has %0b last %0b, got byte %02h has %0b last %0b",
                     want.data, want.has, want.last, got.data, got.has, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("stream_find_and_replace_top_test NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [WordW-1:0] value);
    wait_drained();
    repeat (SettleWait) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    unique case (idx)
      CfgPatLen: begin
        pat_len_r = value[LenW-1:0];
        clear_window();
      end
      CfgPatBytes:  pat_r = value;
      CfgReplLen:   rep_len_r = value[LenW-1:0];
      CfgReplBytes: rep_r = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic setup_search(input logic [LenW-1:0] plen, input logic [WordW-1:0] pat,
                              input logic [LenW-1:0] rlen, input logic [WordW-1:0] rep);
    write_reg(CfgPatLen, WordW'(plen));
    write_reg(CfgPatBytes, pat);
    write_reg(CfgReplLen, WordW'(rlen));
    write_reg(CfgReplBytes, rep);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [ByteW-1:0] b, input logic is_last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = is_last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_replace(b, is_last);
    @(negedge clk_i);
  endtask

  task automatic test_default_regs();
    send_gap_pct   = 34;
    recv_stall_pct = 75;
    // reset setup deletes every zero byte, so the final zero leaves an empty end word
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    in_valid = 1'b0;
  endtask

  task automatic test_full_length_match();
    int i;
    setup_search(4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_word(8'h00, 1'b0);
    for (i = 0; i < 8; i++) send_word(8'hFF, i == 7);
    in_valid = 1'b0;
  endtask

  task automatic test_length_clamps();
    // zero pattern length acts as one, oversize replacement length as eight
    setup_search(4'd0, 64'h41, 4'd15, 64'hFEDC_BA98_7654_3210);
    send_word(8'h41, 1'b1);
    in_valid = 1'b0;
    // oversize pattern length acts as eight, short text only flushes
    write_reg(CfgPatLen, WordW'(4'd15));
    send_word(8'h41, 1'b0);
    send_word(8'h42, 1'b1);
    in_valid = 1'b0;
  endtask

  task automatic test_midtext_writes();
    setup_search(4'd2, 64'h6261, 4'd1, 64'h58);
    send_word(8'h61, 1'b0);
    in_valid = 1'b0;
    write_reg(CfgPatBytes, 64'h6361);
    send_word(8'h63, 1'b0);
    send_word(8'h61, 1'b0);
    in_valid = 1'b0;
    // rewriting the length drops the pending byte
    write_reg(CfgPatLen, WordW'(4'd2));
    send_word(8'h63, 1'b1);
    in_valid = 1'b0;
  endtask

  task automatic random_setup();
    logic [LenW-1:0]  plen;
    logic [LenW-1:0]  rlen;
    logic [WordW-1:0] pat;
    int               i;
    if ($urandom_range(9) == 0)
      plen = ($urandom_range(1) == 0) ? 4'd0 : LenW'($urandom_range(9, 15));
    else
      plen = LenW'($urandom_range(1, 8));
    if ($urandom_range(9) == 0)
      rlen = LenW'($urandom_range(9, 15));
    else
      rlen = LenW'($urandom_range(0, 8));
    if ($urandom_range(1) == 0) begin
      pat = {$urandom, $urandom};
    end else begin
      // two-letter pattern to provoke overlapping near-matches
      for (i = 0; i < 8; i++) pat[8*i +: 8] = ($urandom_range(1) == 0) ? 8'h61 : 8'h62;
    end
    setup_search(plen, pat, rlen, {$urandom, $urandom});
  endtask

  task automatic send_random_text(output int n_sent);
    logic [ByteW-1:0] text [$];
    int               plen;
    int               len;
    int               r;
    int               cut;
    int               k;
    plen = eff_pat_len();
    len  = $urandom_range(1, 14);
    while (text.size() < len) begin
      r = $urandom_range(99);
      if (r < 35) begin
        for (k = 0; k < plen; k++) text.push_back(pat_r[8*k +: 8]);
      end else if (r < 50 && plen > 1) begin
        cut = $urandom_range(1, plen - 1);
        for (k = 0; k < cut; k++) text.push_back(pat_r[8*k +: 8]);
        text.push_back(ByteW'($urandom_range(255)));
      end else if (r < 80) begin
        k = $urandom_range(0, plen - 1);
        text.push_back(pat_r[8*k +: 8]);
      end else begin
        text.push_back(ByteW'($urandom_range(255)));
      end
    end
    for (k = 0; k < text.size(); k++) send_word(text[k], k == text.size() - 1);
    in_valid = 1'b0;
    n_sent = text.size();
  endtask

  task automatic test_random_texts(input int gap_pct, input int stall_pct, input int n_items);
    int sent;
    int n;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(2) == 0) random_setup();
      send_random_text(n);
      sent += n;
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    setup_search(4'd1, 64'h5A, 4'd8, {$urandom, $urandom});
    ready_hold_cycles = 150;
    for (i = 0; i < 24; i++)
      send_word(($urandom_range(4) == 0) ? ByteW'($urandom_range(255)) : 8'h5A, i == 23);
    in_valid = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid          = 1'b0;
    in_byte           = '0;
    in_last           = 1'b0;
    out_ready         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CfgPatLen;
    cfg_data          = '0;
    pat_len_r         = 4'd1;
    pat_r             = '0;
    rep_len_r         = '0;
    rep_r             = '0;
    send_gap_pct      = 0;
    recv_stall_pct    = 0;
    ready_hold_cycles = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    clear_window();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_regs();
    test_full_length_match();
    test_length_clamps();
    test_midtext_writes();
    test_random_texts(34, 75, 40);
    test_random_texts(75, 34, 40);
    test_output_backpressure();
    test_random_texts(0, 0, 40);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("stream_find_and_replace_top_test OK");
    end else begin
      $display("stream_find_and_replace_top_test NOT OK");
    end
    $finish;
  end

endmodule
